/* rtl/bgc_pkg.sv */
// Shared types and constants for the button gesture classifier.
// Holds ring sizing, register indexes, event kinds and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int unsigned RING_DEPTH = 8;
  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned IDX_W = $clog2(RING_DEPTH + 1);

  localparam int unsigned TS_W = 32;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned TAPS_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE = 2'd3;

  localparam logic [CFG_W-1:0] RST_LONG_PRESS = 16'd1000;
  localparam logic [CFG_W-1:0] RST_GAP_MIN = 16'd50;
  localparam logic [CFG_W-1:0] RST_GAP_MAX = 16'd400;
  localparam logic [CFG_W-1:0] RST_PAUSE = 16'd500;

  localparam logic [KIND_W-1:0] KIND_SHORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LONG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MULTI = 2'd2;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam logic LVL_PRESSED = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_DECIDE,
    S_WALK,
    S_FINISH
  } state_e;

  // Ring slot that lies off entries after pos; off stays below twice the depth.
  function automatic logic [PTR_W-1:0] ring_slot(logic [PTR_W-1:0] pos,
                                                 logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = (IDX_W + 1)'(pos) + (IDX_W + 1)'(off);
    if (sum >= (IDX_W + 1)'(RING_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

/* rtl/button_gesture_classifier_core.sv */
// Button gesture classifier core: press and release rings in synchronous memories,
// a controller that evaluates short press, long press and multi-tap.
// Depends on bgc_pkg.
`timescale 1ns / 1ps

// Channel     | Direction | tdata (low bit up)                 | tuser
// s_axis      | in        | time_stamp[31:0], pin_level, pad   | op
// m_axis      | out       | tap_count[4:0], pad                | event_kind[1:0]
// cfg         | in        | cfg_wdata_i holds 16-bit register  | cfg_idx_i selects it
//
// An edge transfer is written to its ring in the cycle it is accepted.
// An evaluate transfer steps through S_HEAD and S_DECIDE, and on through S_WALK and S_FINISH
// when the press ring walk runs: the walk reads one press entry per cycle through the memory port.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
// A detection waits while the output register is full; input is taken only when idle.

module button_gesture_classifier_core
  import bgc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // time_stamp[31:0], pin_level[32]
  input  logic                   s_axis_tuser,  // op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // tap_count[4:0]
  output logic [KIND_W-1:0]      m_axis_tuser,  // event_kind[1:0]
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  logic [CFG_W-1:0] long_press_q, gap_min_q, gap_max_q, pause_q;

  logic [TS_W-1:0] press_mem [RING_DEPTH];
  logic [TS_W-1:0] rel_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] press_vld_q, press_vld_d, rel_vld_q, rel_vld_d;
  logic [PTR_W-1:0] press_pos_q, press_pos_d, rel_pos_q, rel_pos_d;

  logic [PTR_W-1:0] press_raddr, rel_raddr;
  logic [TS_W-1:0] press_rd_q, rel_rd_q;
  logic press_rd_vld_q, rel_rd_vld_q;
  logic [TS_W-1:0] press_val, rel_val;

  state_e state_q, state_d;
  logic [TS_W-1:0] ts_q, since_press_q, since_rel_q, held_q, prev_q;
  logic p_nz_q, r_nz_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [TAPS_W-1:0] taps_q, taps_d;

  logic out_vld_q, out_vld_d;
  logic [KIND_W-1:0] out_kind_q;
  logic [TAPS_W-1:0] out_taps_q;

  logic in_xfer, edge_press, edge_rel;
  logic can_emit, emit_en, head_load;
  logic [KIND_W-1:0] emit_kind;
  logic is_long, is_short, do_walk, gap_hit;
  logic [TS_W-1:0] in_ts, gap;

  assign in_ts = s_axis_tdata[TS_W-1:0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign edge_press = in_xfer && (s_axis_tuser == OP_EDGE) && (s_axis_tdata[TS_W] == LVL_PRESSED);
  assign edge_rel = in_xfer && (s_axis_tuser == OP_EDGE) && (s_axis_tdata[TS_W] != LVL_PRESSED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= RST_LONG_PRESS;
      gap_min_q <= RST_GAP_MIN;
      gap_max_q <= RST_GAP_MAX;
      pause_q <= RST_PAUSE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LONG_PRESS: long_press_q <= cfg_wdata_i;
        REG_GAP_MIN: gap_min_q <= cfg_wdata_i;
        REG_GAP_MAX: gap_max_q <= cfg_wdata_i;
        REG_PAUSE: pause_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_IDLE: press_raddr = ring_slot(press_pos_q, IDX_W'(RING_DEPTH - 1));
      S_WALK: press_raddr = ring_slot(press_pos_q, idx_q);
      default: press_raddr = ring_slot(press_pos_q, '0);
    endcase
    rel_raddr = ring_slot(rel_pos_q, IDX_W'(RING_DEPTH - 1));
  end

  always_ff @(posedge clk_i) begin
    if (edge_press) begin
      press_mem[press_pos_q] <= in_ts;
    end
    press_rd_q <= press_mem[press_raddr];
    press_rd_vld_q <= press_vld_q[press_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (edge_rel) begin
      rel_mem[rel_pos_q] <= in_ts;
    end
    rel_rd_q <= rel_mem[rel_raddr];
    rel_rd_vld_q <= rel_vld_q[rel_raddr];
  end

  assign press_val = press_rd_vld_q ? press_rd_q : '0;
  assign rel_val = rel_rd_vld_q ? rel_rd_q : '0;

  assign can_emit = !out_vld_q || m_axis_tready;
  assign is_long = (since_press_q >= TS_W'(long_press_q)) && (since_rel_q > since_press_q);
  assign is_short = r_nz_q && (held_q > TS_W'(gap_max_q[CFG_W-1:1]))
                    && (held_q < TS_W'(long_press_q));
  assign do_walk = since_press_q >= TS_W'(pause_q);
  assign gap = press_val - prev_q;
  assign gap_hit = (idx_q >= IDX_W'(2)) && (gap >= TS_W'(gap_min_q))
                   && (gap <= TS_W'(gap_max_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (s_axis_tuser == OP_EVAL)) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: state_d = S_DECIDE;
      S_DECIDE: begin
        if (!p_nz_q) begin
          state_d = S_IDLE;
        end else if (is_long || is_short) begin
          if (can_emit) begin
            state_d = S_IDLE;
          end
        end else if (do_walk) begin
          state_d = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WALK: begin
        if (idx_q == IDX_W'(RING_DEPTH)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (taps_q == '0 || can_emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    head_load = 1'b0;
    emit_en = 1'b0;
    emit_kind = KIND_SHORT;
    idx_d = idx_q;
    taps_d = taps_q;
    case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_HEAD: head_load = 1'b1;
      S_DECIDE: begin
        idx_d = IDX_W'(1);
        taps_d = '0;
        if (p_nz_q && is_long) begin
          emit_en = can_emit;
          emit_kind = KIND_LONG;
        end else if (p_nz_q && is_short) begin
          emit_en = can_emit;
          emit_kind = KIND_SHORT;
        end
      end
      S_WALK: begin
        idx_d = idx_q + IDX_W'(1);
        if (gap_hit) begin
          taps_d = taps_q + TAPS_W'(1);
        end
      end
      S_FINISH: begin
        emit_en = (taps_q != '0) && can_emit;
        emit_kind = KIND_MULTI;
      end
      default: ;
    endcase
  end

  always_comb begin
    press_vld_d = press_vld_q;
    rel_vld_d = rel_vld_q;
    press_pos_d = press_pos_q;
    rel_pos_d = rel_pos_q;
    if (edge_press) begin
      press_vld_d[press_pos_q] = 1'b1;
      press_pos_d = ring_slot(press_pos_q, IDX_W'(1));
    end
    if (edge_rel) begin
      rel_vld_d[rel_pos_q] = 1'b1;
      rel_pos_d = ring_slot(rel_pos_q, IDX_W'(1));
    end
    if (emit_en) begin
      press_vld_d = '0;
      rel_vld_d = '0;
    end
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (emit_en) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      press_vld_q <= '0;
      rel_vld_q <= '0;
      press_pos_q <= '0;
      rel_pos_q <= '0;
      out_vld_q <= 1'b0;
      idx_q <= '0;
      taps_q <= '0;
    end else begin
      state_q <= state_d;
      press_vld_q <= press_vld_d;
      rel_vld_q <= rel_vld_d;
      press_pos_q <= press_pos_d;
      rel_pos_q <= rel_pos_d;
      out_vld_q <= out_vld_d;
      idx_q <= idx_d;
      taps_q <= taps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ts_q <= in_ts;
    end
    if (head_load) begin
      since_press_q <= ts_q - press_val;
      since_rel_q <= ts_q - rel_val;
      held_q <= rel_val - press_val;
      p_nz_q <= press_val != '0;
      r_nz_q <= rel_val != '0;
    end
    if (state_q == S_WALK) begin
      prev_q <= press_val;
    end
    if (emit_en) begin
      out_kind_q <= emit_kind;
      out_taps_q <= (emit_kind == KIND_MULTI) ? taps_q : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser = out_kind_q;
  assign m_axis_tdata = OUT_TDATA_W'(out_taps_q);

  a_emit_clears_rings: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (press_vld_q == '0 && rel_vld_q == '0))
    else $error("rings not cleared on detection");

  a_taps_only_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_MULTI) |-> (m_axis_tdata == '0))
    else $error("tap count on a non multi-tap event");

  a_walk_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (idx_q >= IDX_W'(1) && idx_q <= IDX_W'(RING_DEPTH)))
    else $error("walk index out of range");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tuser) && $stable(m_axis_tdata)))
    else $error("pending event overwritten");

endmodule

/* tb/bgc_checker.sv */
// Checker for the button gesture classifier: watches the input, output and register ports,
// keeps its own copy of the press and release rings and compares every event transfer.
// Depends on bgc_pkg.
`timescale 1ns / 1ps

module bgc_checker
  import bgc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tready_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,  // time_stamp[31:0], pin_level[32]
  input  logic                   s_tuser_i,  // op
  input  logic                   m_tvalid_i,
  input  logic                   m_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_tdata_i,  // tap_count[4:0]
  input  logic [KIND_W-1:0]      m_tuser_i,  // event_kind[1:0]
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     items_seen_o,
  output int                     events_seen_o
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAPS_W-1:0] taps;
  } gesture_event_t;

  gesture_event_t expected_events[$];

  logic [TS_W-1:0]  press_hist[RING_DEPTH];
  logic [TS_W-1:0]  release_hist[RING_DEPTH];
  logic [PTR_W-1:0] press_wp;
  logic [PTR_W-1:0] release_wp;
  logic [CFG_W-1:0] long_ticks;
  logic [CFG_W-1:0] gap_lo;
  logic [CFG_W-1:0] gap_hi;
  logic [CFG_W-1:0] pause_ticks;

  gesture_event_t new_ev;
  gesture_event_t oldest_ev;
  bit             new_fired;

  function automatic int unsigned ring_pos(logic [PTR_W-1:0] base, int unsigned off);
    return (int'(base) + off) % RING_DEPTH;
  endfunction

  task automatic clear_history();
    for (int i = 0; i < RING_DEPTH; i++) begin
      press_hist[i] = '0;
      release_hist[i] = '0;
    end
  endtask

  task automatic report_mismatch(string what, int want, int got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    fail_count_o++;
  endtask

  // Applies one input transfer to the ring copy and works out the event it causes.
  task automatic classify_gesture(input logic op, input logic [TS_W-1:0] ts,
                                  input logic lvl, output bit fired,
                                  output gesture_event_t ev);
    logic [TS_W-1:0] last_press;
    logic [TS_W-1:0] last_release;
    logic [TS_W-1:0] since_press;
    logic [TS_W-1:0] since_release;
    logic [TS_W-1:0] held;
    logic [TS_W-1:0] gap;
    int unsigned     taps;
    fired = 1'b0;
    ev = '0;
    if (op == OP_EDGE) begin
      if (lvl == LVL_PRESSED) begin
        press_hist[press_wp] = ts;
        press_wp = PTR_W'(ring_pos(press_wp, 1));
      end else begin
        release_hist[release_wp] = ts;
        release_wp = PTR_W'(ring_pos(release_wp, 1));
      end
      return;
    end
    last_press = press_hist[ring_pos(press_wp, RING_DEPTH - 1)];
    last_release = release_hist[ring_pos(release_wp, RING_DEPTH - 1)];
    if (last_press == '0) return;
    since_press = ts - last_press;
    since_release = ts - last_release;
    if (since_press >= TS_W'(long_ticks) && since_release > since_press) begin
      fired = 1'b1;
      ev.kind = KIND_LONG;
      clear_history();
      return;
    end
    held = last_release - last_press;
    if (last_release != '0 && held > TS_W'(gap_hi >> 1) && held < TS_W'(long_ticks)) begin
      fired = 1'b1;
      ev.kind = KIND_SHORT;
      clear_history();
      return;
    end
    if (since_press >= TS_W'(pause_ticks)) begin
      taps = 0;
      for (int i = RING_DEPTH - 1; i >= 1; i--) begin
        gap = press_hist[ring_pos(press_wp, i)] - press_hist[ring_pos(press_wp, i - 1)];
        if (gap >= TS_W'(gap_lo) && gap <= TS_W'(gap_hi)) taps++;
      end
      if (taps != 0) begin
        fired = 1'b1;
        ev.kind = KIND_MULTI;
        ev.taps = TAPS_W'(taps);
        clear_history();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_history();
      press_wp = '0;
      release_wp = '0;
      long_ticks = RST_LONG_PRESS;
      gap_lo = RST_GAP_MIN;
      gap_hi = RST_GAP_MAX;
      pause_ticks = RST_PAUSE;
      expected_events.delete();
      fail_count_o = 0;
      pending_o = 0;
      items_seen_o = 0;
      events_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LONG_PRESS: long_ticks = cfg_wdata_i;
          REG_GAP_MIN: gap_lo = cfg_wdata_i;
          REG_GAP_MAX: gap_hi = cfg_wdata_i;
          REG_PAUSE: pause_ticks = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        items_seen_o++;
        classify_gesture(s_tuser_i, s_tdata_i[TS_W-1:0], s_tdata_i[TS_W], new_fired, new_ev);
        if (new_fired) expected_events.push_back(new_ev);
      end
      if (m_tvalid_i && m_tready_i) begin
        events_seen_o++;
        if (expected_events.size() == 0) begin
          report_mismatch("event with none expected, kind", -1, int'(m_tuser_i));
        end else begin
          oldest_ev = expected_events.pop_front();
          if (m_tuser_i !== oldest_ev.kind) begin
            report_mismatch("event_kind", int'(oldest_ev.kind), int'(m_tuser_i));
          end
          if (m_tdata_i[TAPS_W-1:0] !== oldest_ev.taps) begin
            report_mismatch("tap_count", int'(oldest_ev.taps), int'(m_tdata_i[TAPS_W-1:0]));
          end
        end
      end
      pending_o = expected_events.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Top of the button gesture classifier testbench: clock, reset, edge and evaluate stimulus,
// register settings and the verdict; checking is done by bgc_checker.
// Depends on bgc_pkg, bgc_checker and button_gesture_classifier_core.
`timescale 1ns / 1ps

module tb_top;
  import bgc_pkg::*;

  localparam int PHASE_ITEMS = 265;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT = 20000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_valid;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data;
  logic                   s_user;
  logic                   m_valid;
  logic                   m_ready;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [KIND_W-1:0]      m_user;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]       cfg_wdata;

  int fail_count;
  int pending;
  int items_seen;
  int events_seen;

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          stall_cycles;
  int          settings_used;
  logic [31:0] now_tick;
  logic [15:0] cur_long;
  logic [15:0] cur_gmin;
  logic [15:0] cur_gmax;
  logic [15:0] cur_pause;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  button_gesture_classifier_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  bgc_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_valid),
    .s_tready_i    (s_ready),
    .s_tdata_i     (s_data),
    .s_tuser_i     (s_user),
    .m_tvalid_i    (m_valid),
    .m_tready_i    (m_ready),
    .m_tdata_i     (m_data),
    .m_tuser_i     (m_user),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .items_seen_o  (items_seen),
    .events_seen_o (events_seen)
  );

  // The event receiver stalls at random and, on request, holds off for a long stretch.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d events outstanding",
               STALL_LIMIT, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [31:0] ts, input logic lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {7'd0, lvl, ts};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic press_at(input logic [31:0] ts);
    send_item(OP_EDGE, ts, LVL_PRESSED);
  endtask

  task automatic release_at(input logic [31:0] ts);
    send_item(OP_EDGE, ts, ~LVL_PRESSED);
  endtask

  task automatic eval_at(input logic [31:0] ts);
    send_item(OP_EVAL, ts, 1'($urandom_range(1)));
  endtask

  // Stops offering input and waits until every expected event has come and the walk is done.
  task automatic wait_quiet();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] lp, input logic [15:0] gmin,
                              input logic [15:0] gmax, input logic [15:0] pause);
    cfg_we <= 1'b1;
    cfg_idx <= REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk_i);
    cfg_idx <= REG_GAP_MIN;
    cfg_wdata <= gmin;
    @(posedge clk_i);
    cfg_idx <= REG_GAP_MAX;
    cfg_wdata <= gmax;
    @(posedge clk_i);
    cfg_idx <= REG_PAUSE;
    cfg_wdata <= pause;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_long = lp;
    cur_gmin = gmin;
    cur_gmax = gmax;
    cur_pause = pause;
    settings_used++;
  endtask

  task automatic long_press_gesture();
    logic [31:0] t;
    t = now_tick;
    press_at(t);
    if ($urandom_range(3) == 0) eval_at(t + $urandom_range(cur_long));
    eval_at(t + cur_long + $urandom_range(60));
    now_tick = t + cur_long + 32'd100 + $urandom_range(2000);
  endtask

  task automatic short_press_gesture();
    logic [31:0] t;
    logic [31:0] held;
    int unsigned lo;
    t = now_tick;
    lo = (cur_gmax >> 1) + 1;
    if (lo + 1 < cur_long) held = $urandom_range(cur_long - 1, lo);
    else held = $urandom_range(cur_gmax + 10);
    press_at(t);
    release_at(t + held);
    eval_at(t + held + $urandom_range(40));
    now_tick = t + held + 32'd100 + $urandom_range(3000);
  endtask

  task automatic multi_tap_gesture();
    logic [31:0] t;
    logic [31:0] gap;
    logic [31:0] hold;
    int          taps;
    t = now_tick;
    taps = $urandom_range(8, 2);
    for (int k = 0; k < taps; k++) begin
      press_at(t);
      if ($urandom_range(4) != 0) begin
        hold = ((cur_gmax >> 1) == 0) ? 32'd1 : $urandom_range(cur_gmax >> 1, 1);
        release_at(t + hold);
      end
      if (k < taps - 1) begin
        if ($urandom_range(9) == 0) gap = cur_gmax + 1 + $urandom_range(500);
        else if (cur_gmax >= cur_gmin) gap = $urandom_range(cur_gmax, cur_gmin);
        else gap = $urandom_range(cur_gmin, cur_gmax);
        if ($urandom_range(5) == 0) eval_at(t + $urandom_range(gap));
        t = t + gap;
      end
    end
    eval_at(t + cur_pause + $urandom_range(50));
    now_tick = t + cur_pause + 32'd200 + $urandom_range(2000);
  endtask

  task automatic noise_burst();
    int n;
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      send_item(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)));
    end
  endtask

  task automatic run_random(input int phase);
    int  start;
    int  pick;
    bit  mid_done;
    start = items_seen;
    mid_done = 1'b0;
    while (items_seen - start < PHASE_ITEMS) begin
      if (!mid_done && items_seen - start > PHASE_ITEMS / 2) begin
        mid_done = 1'b1;
        if (phase == 1 || phase == 4) hold_req = 1'b1;
        if (phase == 2) wait_quiet();
      end
      pick = $urandom_range(99);
      if (pick < 28) long_press_gesture();
      else if (pick < 54) short_press_gesture();
      else if (pick < 85) multi_tap_gesture();
      else noise_burst();
    end
  endtask

  initial begin
    s_valid <= 1'b0;
    s_user <= OP_EDGE;
    s_data <= '0;
    m_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_LONG_PRESS;
    cfg_wdata <= '0;
    rst_ni <= 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_cycles = 0;
    settings_used = 1;
    tx_idle_pct = 12;
    rx_idle_pct = 74;
    cur_long = RST_LONG_PRESS;
    cur_gmin = RST_GAP_MIN;
    cur_gmax = RST_GAP_MAX;
    cur_pause = RST_PAUSE;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset register values.
    eval_at(32'd5);
    release_at(32'hFFFF_FFFF);
    eval_at(32'd0);
    press_at(32'd0);
    eval_at(32'd2000);
    press_at(32'hFFFF_FF00);
    eval_at(32'h0000_03E8);
    press_at(32'd10000);
    eval_at(32'd11000);
    press_at(32'd20000);
    release_at(32'd20300);
    eval_at(32'd20310);
    press_at(32'd30000);
    release_at(32'd30020);
    press_at(32'd30100);
    release_at(32'd30120);
    press_at(32'd30450);
    release_at(32'd30470);
    eval_at(32'd30500);
    eval_at(32'd31000);
    press_at(32'h7FFF_FFFF);
    eval_at(32'hFFFF_FFFF);

    now_tick = $urandom();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_quiet();
      case (ph)
        0: program_regs(16'($urandom_range(3000, 200)), 16'($urandom_range(100, 20)),
                        16'($urandom_range(600, 150)), 16'($urandom_range(1500, 200)));
        1: program_regs('0, '0, '0, '0);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: program_regs(16'hFFFF, '0, 16'hFFFF, '0);
        4: begin
          program_regs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                       16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
          now_tick = 32'hFFFF_0000 + $urandom_range(16'hFFFF);
        end
        default: program_regs(RST_LONG_PRESS, RST_GAP_MIN, RST_GAP_MAX, RST_PAUSE);
      endcase
      if (ph < 2) begin
        tx_idle_pct = 12;
        rx_idle_pct = 74;
      end else if (ph < 4) begin
        tx_idle_pct = 74;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_random(ph);
    end

    wait_quiet();
    $display("summary: %0d input transfers, %0d event transfers, %0d register settings",
             items_seen, events_seen, settings_used);
    $display("covered long, short and multi-tap gestures, wrapped stamps and stalls on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
